// ===== rtl/uhb_pkg.sv =====
// Shared types and codes for the uniform-bin histogram.
`timescale 1ns / 1ps
package uhb_pkg;

	// Command codes carried in s_tuser
	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	// Result kinds loaded into the output register
	localparam logic [1:0] RES_ZERO = 2'd0;
	localparam logic [1:0] RES_ADD  = 2'd1;
	localparam logic [1:0] RES_READ = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_LOW_EDGE    = 2'd0;
	localparam logic [1:0] REG_CLASS_WIDTH = 2'd1;
	localparam logic [1:0] REG_NUM_CLASSES = 2'd2;

	localparam int IDX_BITS  = 6;
	localparam int EDGE_BITS = 40;
	localparam int OUT_COUNT_BITS = 32;

	// Controller to datapath
	typedef struct packed {
		logic       load_in;
		logic       scan_step;
		logic       mem_rd;
		logic       mem_wr;
		logic       mul;
		logic       clr_step;
		logic       load_out;
		logic [1:0] res_kind;
	} uhb_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [1:0] cmd;
		logic       first;
		logic       below;
		logic       found;
		logic       clr_done;
	} uhb_stat_t;

endpackage

// ===== rtl/uhb_dp.sv =====
// Datapath: configuration, count memory, class edge walk and output register.
`timescale 1ns / 1ps
module uhb_dp import uhb_pkg::*; #(
	parameter int MAX_CLASSES = 64,
	parameter int COUNT_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic [39:0] in_data,
	input  logic [1:0]  in_user,
	input  uhb_cmd_t    cmd,
	output uhb_stat_t   stat,
	output logic [79:0] out_data,
	output logic        out_user
);

	localparam int IW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;

	logic signed [31:0] low_edge_q;
	logic [30:0]        class_width_q;
	logic [6:0]         num_classes_q;

	logic [1:0]         cmd_q;
	logic signed [31:0] sample_q;
	logic [5:0]         sel_q;
	logic [6:0]         idx_q;
	logic signed [EDGE_BITS-1:0] edge_q;
	logic [36:0]        prod_q;
	logic [COUNT_BITS-1:0] rd_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [IW-1:0]      clr_q;

	logic [COUNT_BITS-1:0] mem [MAX_CLASSES];

	logic [IDX_BITS-1:0]       out_idx_q;
	logic                      out_hit_q;
	logic [OUT_COUNT_BITS-1:0] out_cnt_q;
	logic [EDGE_BITS-1:0]      out_edge_q;

	logic [6:0]  n_use;
	logic [6:0]  last_idx;
	logic signed [EDGE_BITS-1:0] edge_next;
	logic signed [EDGE_BITS-1:0] sample_x;
	logic signed [EDGE_BITS-1:0] low_x;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic [IW-1:0] rd_addr;
	logic          sel_in_use;

	// Classes in use: zero acts as one, cap at the memory depth
	always_comb begin
		if (num_classes_q == 7'd0) begin
			n_use = 7'd1;
		end else if ({4'd0, num_classes_q} > 11'(MAX_CLASSES)) begin
			n_use = 7'(MAX_CLASSES);
		end else begin
			n_use = num_classes_q;
		end
	end

	assign last_idx   = n_use - 7'd1;
	assign low_x      = EDGE_BITS'(low_edge_q);
	assign sample_x   = EDGE_BITS'(sample_q);
	assign edge_next  = edge_q + $signed({9'd0, class_width_q});
	assign cnt_inc    = (rd_q == {COUNT_BITS{1'b1}}) ? rd_q : rd_q + COUNT_BITS'(1);
	assign rd_addr    = (cmd_q == CMD_READ) ? IW'(sel_q) : IW'(idx_q);
	assign sel_in_use = {1'b0, sel_q} < n_use;

	assign stat.cmd      = cmd_q;
	assign stat.first    = idx_q == 7'd0;
	assign stat.below    = sample_x < edge_q;
	assign stat.found    = (idx_q == last_idx) || (sample_x < edge_next);
	assign stat.clr_done = clr_q == IW'(MAX_CLASSES - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_edge_q    <= '0;
			class_width_q <= 31'd65536;
			num_classes_q <= 7'd64;
			clr_q         <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_LOW_EDGE:    low_edge_q    <= cfg_data;
					REG_CLASS_WIDTH: class_width_q <= cfg_data[30:0];
					REG_NUM_CLASSES: num_classes_q <= cfg_data[6:0];
					default: ;
				endcase
			end
			if (cmd.clr_step) begin
				clr_q <= stat.clr_done ? '0 : clr_q + IW'(1);
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q    <= in_user;
			sample_q <= in_data[31:0];
			sel_q    <= in_data[37:32];
			idx_q    <= '0;
			edge_q   <= low_x;
		end else if (cmd.scan_step) begin
			idx_q  <= idx_q + 7'd1;
			edge_q <= edge_next;
		end
		if (cmd.mul) begin
			prod_q <= 37'(sel_q) * 37'(class_width_q);
		end
		if (cmd.mem_wr) begin
			cnt_q <= cnt_inc;
		end
	end

	// Count memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			mem[clr_q] <= '0;
		end else if (cmd.mem_wr) begin
			mem[IW'(idx_q)] <= cnt_inc;
		end
		if (cmd.mem_rd) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			case (cmd.res_kind)
				RES_ADD: begin
					out_idx_q  <= IDX_BITS'(idx_q);
					out_hit_q  <= 1'b1;
					out_cnt_q  <= OUT_COUNT_BITS'(cnt_q);
					out_edge_q <= edge_q;
				end
				RES_READ: begin
					out_idx_q  <= sel_q;
					out_hit_q  <= 1'b0;
					out_cnt_q  <= sel_in_use ? OUT_COUNT_BITS'(rd_q) : '0;
					out_edge_q <= low_x + $signed({3'd0, prod_q});
				end
				default: begin
					out_idx_q  <= '0;
					out_hit_q  <= 1'b0;
					out_cnt_q  <= '0;
					out_edge_q <= '0;
				end
			endcase
		end
	end

	assign out_data = {2'b00, out_edge_q, out_cnt_q, out_idx_q};
	assign out_user = out_hit_q;

`ifndef NO_ASSERTIONS
	a_no_dual_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clr_step && cmd.mem_wr))
		else $error("clear sweep and count update collide");
	a_scan_not_past_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> idx_q != last_idx)
		else $error("edge walk stepped past the last class");
`endif

endmodule

// ===== rtl/uhb_ctrl.sv =====
// Controller: sequences add, read and clear transactions over the datapath.
`timescale 1ns / 1ps
module uhb_ctrl import uhb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  uhb_stat_t stat,
	output uhb_cmd_t  cmd
);

	localparam logic [2:0] ST_INIT     = 3'd0;
	localparam logic [2:0] ST_IDLE     = 3'd1;
	localparam logic [2:0] ST_DISPATCH = 3'd2;
	localparam logic [2:0] ST_SCAN     = 3'd3;
	localparam logic [2:0] ST_UPDATE   = 3'd4;
	localparam logic [2:0] ST_CLEAR    = 3'd5;
	localparam logic [2:0] ST_DONE     = 3'd6;

	logic [2:0] state_q, state_d;
	logic [1:0] kind_q, kind_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		cmd     = '0;
		unique case (state_q)
			ST_INIT: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (stat.cmd)
					CMD_ADD: state_d = ST_SCAN;
					CMD_READ: begin
						cmd.mul    = 1'b1;
						cmd.mem_rd = 1'b1;
						kind_d     = RES_READ;
						state_d    = ST_DONE;
					end
					CMD_CLEAR: state_d = ST_CLEAR;
					default: begin
						kind_d  = RES_ZERO;
						state_d = ST_DONE;
					end
				endcase
			end
			ST_SCAN: begin
				if (stat.first && stat.below) begin
					kind_d  = RES_ZERO;
					state_d = ST_DONE;
				end else if (stat.found) begin
					cmd.mem_rd = 1'b1;
					state_d    = ST_UPDATE;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			ST_UPDATE: begin
				cmd.mem_wr = 1'b1;
				kind_d     = RES_ADD;
				state_d    = ST_DONE;
			end
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_done) begin
					kind_d  = RES_ZERO;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		cmd.res_kind = kind_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			kind_q      <= RES_ZERO;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result overwrites one not yet taken");
	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("loaded result not presented");
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_step |-> !in_ready)
		else $error("input taken during clear sweep");
`endif

endmodule

// ===== rtl/uniform_histogram_binning.sv =====
// Top level of the uniform-bin histogram.
`timescale 1ns / 1ps
// Usage: one command per s_ transaction (s_tuser = 0 add, 1 read, 2 clear, 3 no-op);
// each gives exactly one m_ transaction. Add bins a Q16.16 sample into the first
// class whose interval holds it and returns index, hit, new count and lower edge.
// Read returns one class's count and lower edge. Clear zeroes all counts.
// Configuration: cfg_valid/cfg_index/cfg_data write low_edge (0), class_width (1),
// num_classes (2); cfg_ready is always high. Write only while the block is idle.
// Sequencing: one command is in flight at a time; s_tready is high only when idle.
// Add walks the class edges one class per cycle, stopping at the class hit, then
// does one count read-modify-write. A sample above the last class is binned into
// the last class; one below the first class gives a zero result with hit low.
// Read does one multiply for the edge and one count memory read; no-op does neither.
// Clear zeroes the count memory one entry per cycle through its single write port.
// Commands do not overlap: s_tready returns in the cycle after the result is loaded.
// Reset: registers take their reset values and the same clearing pass runs with
// s_tready low.
// Stall: the result waits in the output register while m_tready is low; the
// next command may be accepted and worked, and waits only to be loaded.
module uniform_histogram_binning import uhb_pkg::*; #(
	parameter int MAX_CLASSES = 64,
	parameter int COUNT_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // sample[31:0], class_sel[37:32], zero pad
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // class_index[5:0], count[37:6], lower_edge[77:38], pad
	output logic        m_tuser,   // hit
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	uhb_cmd_t  cmd;
	uhb_stat_t stat;

	assign cfg_ready = 1'b1;

	uhb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	uhb_dp #(
		.MAX_CLASSES (MAX_CLASSES),
		.COUNT_BITS  (COUNT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_tdata),
		.in_user   (s_tuser),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (m_tdata),
		.out_user  (m_tuser)
	);

endmodule
